// ===== rtl/lrcv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Log record CRC validator package
// Shared types, record layout constants and the CRC-32 byte update.
// ----------------------------------------------------------------------------
package lrcv_pkg;

  localparam int unsigned MAX_DIM_DEF = 16384;
  localparam int unsigned CFG_W       = 15;
  localparam int unsigned HDR_BYTES   = 24;

  // Header byte offsets.
  localparam int unsigned IDX_END  = 8;
  localparam int unsigned ID_END   = 16;
  localparam int unsigned DIM_END  = 20;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  typedef enum logic [2:0] {
    VERDICT_VALID      = 3'd0,
    VERDICT_INDEX      = 3'd1,
    VERDICT_DIM        = 3'd2,
    VERDICT_CRC        = 3'd3,
    VERDICT_INCOMPLETE = 3'd4,
    VERDICT_NONE       = 3'd5
  } verdict_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       region_end;
  } item_t;

  typedef struct packed {
    logic [31:0] record_index;
    logic [63:0] record_vid;
    verdict_t    verdict;
    logic [31:0] valid_count;
    logic        scan_done;
  } result_t;

  // Reflected CRC-32 update by one byte, bit at a time.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = {24'd0, crc[7:0] ^ b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c ^ (crc >> 8);
  endfunction

endpackage

// ===== rtl/lrcv_in_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input register
// Captures one byte transaction and holds it until the checker consumes it.
// ----------------------------------------------------------------------------
module lrcv_in_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,
  input  logic             in_tlast,
  input  logic             take,
  output logic             ir_valid,
  output lrcv_pkg::item_t  ir_item
);
  import lrcv_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign in_tready = !valid_r || take;
  assign valid_nxt = (in_tvalid && in_tready) ? 1'b1 : (take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= '{data_byte: in_tdata, region_end: in_tlast};
    end
  end

  assign ir_valid = valid_r;
  assign ir_item  = item_r;

endmodule

// ===== rtl/lrcv_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record checker
// Parses record headers, runs the payload CRC and decides each verdict.
// ----------------------------------------------------------------------------
module lrcv_core #(
  parameter int unsigned MAX_DIM = lrcv_pkg::MAX_DIM_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [lrcv_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic                     ir_valid,
  input  lrcv_pkg::item_t          ir_item,
  input  logic                     out_free,
  output logic                     take,
  output logic                     res_load,
  output lrcv_pkg::result_t        res
);
  import lrcv_pkg::*;

  localparam int unsigned LEN_W = $clog2(HDR_BYTES + 4 * MAX_DIM + 1);
  localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);

  logic [CFG_W-1:0] entry_dim_r;
  logic [LEN_W-1:0] pos_r, pos_nxt;
  logic [31:0]      exp_idx_r, exp_idx_nxt;
  logic [63:0]      idx_shift_r, idx_shift_nxt;
  logic [63:0]      id_shift_r, id_shift_nxt;
  logic [31:0]      dim_shift_r, dim_shift_nxt;
  logic [31:0]      crc_st_r, crc_st_nxt;
  logic [31:0]      run_crc_r, run_crc_nxt;
  logic [31:0]      good_r, good_nxt;
  logic             stopped_r, stopped_nxt;

  logic [DIM_W-1:0] dim_sat;
  logic [LEN_W-1:0] rec_len;
  logic [LEN_W:0]   pos_inc;
  logic             have;
  verdict_t         verdict;
  logic [63:0]      vid;

  assign dim_sat = (32'(entry_dim_r) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(entry_dim_r);
  assign rec_len = LEN_W'(HDR_BYTES) + LEN_W'({dim_sat, 2'b00});
  assign pos_inc = {1'b0, pos_r} + (LEN_W + 1)'(1);

  always_comb begin
    pos_nxt       = pos_r;
    exp_idx_nxt   = exp_idx_r;
    idx_shift_nxt = idx_shift_r;
    id_shift_nxt  = id_shift_r;
    dim_shift_nxt = dim_shift_r;
    crc_st_nxt    = crc_st_r;
    run_crc_nxt   = run_crc_r;
    good_nxt      = good_r;
    stopped_nxt   = stopped_r;
    have          = 1'b0;
    verdict       = VERDICT_NONE;
    vid           = 64'd0;

    if (!stopped_r) begin
      if (pos_r < LEN_W'(IDX_END)) begin
        idx_shift_nxt = {ir_item.data_byte, idx_shift_r[63:8]};
      end else if (pos_r < LEN_W'(ID_END)) begin
        id_shift_nxt = {ir_item.data_byte, id_shift_r[63:8]};
      end else if (pos_r < LEN_W'(DIM_END)) begin
        dim_shift_nxt = {ir_item.data_byte, dim_shift_r[31:8]};
      end else if (pos_r < LEN_W'(HDR_BYTES)) begin
        crc_st_nxt = {ir_item.data_byte, crc_st_r[31:8]};
      end else begin
        run_crc_nxt = crc32_byte(run_crc_r, ir_item.data_byte);
      end

      if (pos_r == LEN_W'(IDX_END - 1) && idx_shift_nxt != {32'd0, exp_idx_r}) begin
        have    = 1'b1;
        verdict = VERDICT_INDEX;
      end else if (pos_r == LEN_W'(DIM_END - 1) && dim_shift_nxt != 32'(dim_sat)) begin
        have    = 1'b1;
        verdict = VERDICT_DIM;
      end else if (pos_r >= LEN_W'(HDR_BYTES - 1) && pos_inc >= {1'b0, rec_len}) begin
        // The record ends here, also when a smaller dimension was written mid record.
        have = 1'b1;
        if ((run_crc_nxt ^ CRC_INIT) == crc_st_nxt) begin
          verdict     = VERDICT_VALID;
          vid         = id_shift_nxt;
          good_nxt    = (good_r != 32'hFFFFFFFF) ? good_r + 32'd1 : good_r;
          exp_idx_nxt = exp_idx_r + 32'd1;
          pos_nxt     = '0;
          run_crc_nxt = CRC_INIT;
        end else begin
          verdict = VERDICT_CRC;
        end
      end else begin
        pos_nxt = pos_inc[LEN_W-1:0];
      end

      if (have && verdict != VERDICT_VALID) begin
        stopped_nxt = 1'b1;
      end
    end

    if (ir_item.region_end && !have) begin
      have    = 1'b1;
      verdict = (!stopped_r && pos_nxt != '0) ? VERDICT_INCOMPLETE : VERDICT_NONE;
    end

    res.record_index = exp_idx_r;
    res.record_vid   = vid;
    res.verdict      = verdict;
    res.valid_count  = good_nxt;
    res.scan_done    = ir_item.region_end;

    if (ir_item.region_end) begin
      pos_nxt     = '0;
      exp_idx_nxt = 32'd0;
      run_crc_nxt = CRC_INIT;
      good_nxt    = 32'd0;
      stopped_nxt = 1'b0;
    end
  end

  // A byte without a result never waits on the output side.
  assign take     = ir_valid && (!have || out_free);
  assign res_load = take && have;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_dim_r <= CFG_W'(1);
      pos_r       <= '0;
      exp_idx_r   <= 32'd0;
      run_crc_r   <= CRC_INIT;
      good_r      <= 32'd0;
      stopped_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        entry_dim_r <= cfg_wr_data;
      end
      if (take) begin
        pos_r     <= pos_nxt;
        exp_idx_r <= exp_idx_nxt;
        run_crc_r <= run_crc_nxt;
        good_r    <= good_nxt;
        stopped_r <= stopped_nxt;
      end
    end
  end

  // Header fields are fully shifted in before they are compared.
  always_ff @(posedge clk) begin
    if (take) begin
      idx_shift_r <= idx_shift_nxt;
      id_shift_r  <= id_shift_nxt;
      dim_shift_r <= dim_shift_nxt;
      crc_st_r    <= crc_st_nxt;
    end
  end

endmodule

// ===== rtl/lrcv_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result register
// Holds one verdict until the downstream side takes the transaction.
// ----------------------------------------------------------------------------
module lrcv_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               res_load,
  input  lrcv_pkg::result_t  res,
  output logic               out_free,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [127:0]       out_tdata,
  output logic [2:0]         out_tuser,
  output logic               out_tlast
);
  import lrcv_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign out_free  = !valid_r || out_tready;
  assign valid_nxt = res_load ? 1'b1 : (out_tready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {res_r.valid_count, res_r.record_vid, res_r.record_index};
  assign out_tuser  = res_r.verdict;
  assign out_tlast  = res_r.scan_done;

endmodule

// ===== rtl/log_record_crc_validator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Log record CRC validator
// Checks sequence number, dimension and payload CRC-32 of streamed log records.
// ----------------------------------------------------------------------------
// The block takes one byte of the log region per cycle and never stalls the
// input on its own: each byte passes the input register and the combinational
// header parsing and table-free CRC update, and the verdict that a byte decides
// is loaded into the result register when that byte is taken from the input
// register. Only a result that the downstream side does not take holds the input
// back. Record length is 24 header bytes plus four bytes per configured word;
// after the first failed record the remaining bytes are swallowed until the
// region's last byte (tlast), which always yields a result with tlast set and
// restarts the scan.
// Write entry_dim only while no transaction is in flight.
module log_record_crc_validator #(
  parameter int unsigned MAX_DIM = lrcv_pkg::MAX_DIM_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [lrcv_pkg::CFG_W-1:0] cfg_wr_data,  // entry_dim
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,     // data_byte
  input  logic                       in_tlast,     // region_end
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [127:0]               out_tdata,    // record_index, record_vid, valid_count
  output logic [2:0]                 out_tuser,    // verdict
  output logic                       out_tlast     // scan_done
);
  import lrcv_pkg::*;

  logic    take;
  logic    ir_valid;
  item_t   ir_item;
  logic    out_free;
  logic    res_load;
  result_t res;

  lrcv_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .take      (take),
    .ir_valid  (ir_valid),
    .ir_item   (ir_item)
  );

  lrcv_core #(
    .MAX_DIM (MAX_DIM)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .ir_valid    (ir_valid),
    .ir_item     (ir_item),
    .out_free    (out_free),
    .take        (take),
    .res_load    (res_load),
    .res         (res)
  );

  lrcv_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_load   (res_load),
    .res        (res),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== rtl/lrcv_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Validator port checker
// Watches the top-level ports for result rules and output handshake hold.
// ----------------------------------------------------------------------------
module lrcv_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [127:0] out_tdata,
  input logic [2:0]   out_tuser,
  input logic         out_tlast
);
  import lrcv_pkg::*;

  // The result register is empty right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

  // Only a valid record carries a vector id.
  a_vid_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != VERDICT_VALID) |-> out_tdata[95:32] == 64'd0)
    else $error("vector id on a non-valid verdict");

  // Incomplete and none verdicts come only from the region end.
  a_end_verdicts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == VERDICT_INCOMPLETE || out_tuser == VERDICT_NONE))
      |-> out_tlast)
    else $error("end-only verdict without scan done");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast)))
    else $error("stalled result changed");

endmodule

bind log_record_crc_validator lrcv_checker u_lrcv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
